// ===== hdl/sci_pkg.sv =====
// Shared constants and pipeline control type for the segment/circle intersection core.
package sci_pkg;

   localparam int COORD_WIDTH_DEF = 32;

   // Pipeline step control handed to the iterative sub-pipelines.
   typedef struct packed {
      logic advance;
      logic valid;
   } sci_step_type;

endpackage

// ===== hdl/segment_circle_intersection_core.sv =====
// Throughput: one request per cycle while no result is held on the output; the depth
// is set by the 2*COORD_WIDTH+2 step square-root pipeline and the COORD_WIDTH+2 step
// divider pipeline.
// A result held on the output stalls the whole pipeline; nothing is dropped.
// Reset clears all valid bits; data registers are not reset.
module segment_circle_intersection_core #(
   parameter int COORD_WIDTH = sci_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_x, start_y, end_x, end_y, centre_x, centre_y, circle_radius, zero pad
   input  logic [((7*COORD_WIDTH+6)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit_count, first_x, first_y, second_x, second_y, zero pad
   output logic [((4*COORD_WIDTH+9)/8)*8-1:0] rsp_tdata
);
   import sci_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;
   localparam int HW  = W + 1;
   localparam int AB  = 2 * HW;
   localparam int PW  = AB + 1;
   localparam int QM  = 2 * AB;
   localparam int NW  = AB + 2;
   localparam int QB  = W + 1;
   localparam int NB  = QB + AB - 1;
   localparam int TOB = ((4 * W + 9) / 8) * 8;
   localparam int SW1 = PW + AB + 2 * W + 2 * DW + 2;
   localparam int SW2 = 2 * W + 4;
   localparam logic signed [W+1:0] PMAX = {3'b000, {(W-1){1'b1}}};
   localparam logic signed [W+1:0] PMIN = {3'b111, {(W-1){1'b0}}};

   logic         en;
   sci_step_type sq_step, dv_step;

   // stage 1: differences
   logic signed [W-1:0]  in_sx, in_sy, in_ex, in_ey, in_cx, in_cy;
   logic [W-2:0]         in_r;
   logic                 s1_vld_ff;
   logic signed [W-1:0]  s1_sx_ff, s1_sy_ff;
   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff, s1_fx_ff, s1_fy_ff;
   logic [W-2:0]         s1_r_ff;

   // stage 2: products
   logic                 s2_vld_ff;
   logic signed [W-1:0]  s2_sx_ff, s2_sy_ff;
   logic signed [DW-1:0] s2_dx_ff, s2_dy_ff;
   logic signed [AB-1:0] s2_dxx_ff, s2_dyy_ff, s2_fdx_ff, s2_fdy_ff, s2_fxx_ff, s2_fyy_ff;
   logic [2*W-3:0]       s2_rr_ff;

   // stage 3: quadratic coefficients
   logic                 s3_vld_ff;
   logic signed [W-1:0]  s3_sx_ff, s3_sy_ff;
   logic signed [DW-1:0] s3_dx_ff, s3_dy_ff;
   logic [AB-1:0]        s3_a_ff;
   logic signed [PW-1:0] s3_h_ff, s3_c_ff;

   // stage 4: partial products of h*h and a*|c|
   logic [AB-1:0]        ah_mag, ac_mag;
   logic                 s4_vld_ff, s4_cneg_ff;
   logic signed [W-1:0]  s4_sx_ff, s4_sy_ff;
   logic signed [DW-1:0] s4_dx_ff, s4_dy_ff;
   logic [AB-1:0]        s4_a_ff;
   logic signed [PW-1:0] s4_h_ff;
   logic [AB-1:0]        s4_hll_ff, s4_hlh_ff, s4_hhh_ff;
   logic [AB-1:0]        s4_all_ff, s4_alh_ff, s4_ahl_ff, s4_ahh_ff;

   // stage 5: full products
   logic [AB:0]          ac_mid;
   logic                 s5_vld_ff, s5_cneg_ff;
   logic signed [W-1:0]  s5_sx_ff, s5_sy_ff;
   logic signed [DW-1:0] s5_dx_ff, s5_dy_ff;
   logic [AB-1:0]        s5_a_ff;
   logic signed [PW-1:0] s5_h_ff;
   logic [QM-1:0]        s5_hsq_ff, s5_acp_ff;

   // stage 6: discriminant
   logic [QM:0]          q_in;
   logic                 s6_vld_ff, s6_qneg_ff, s6_azero_ff;
   logic signed [W-1:0]  s6_sx_ff, s6_sy_ff;
   logic signed [DW-1:0] s6_dx_ff, s6_dy_ff;
   logic [AB-1:0]        s6_a_ff;
   logic signed [PW-1:0] s6_h_ff;
   logic [QM-1:0]        s6_q_ff;

   // square root output
   logic                 sq_vld;
   logic [AB-1:0]        sq_root;
   logic [SW1-1:0]       sq_side;
   logic signed [PW-1:0] sq_h;
   logic [AB-1:0]        sq_a;
   logic signed [W-1:0]  sq_sx, sq_sy;
   logic signed [DW-1:0] sq_dx, sq_dy;
   logic                 sq_qneg, sq_azero;

   // stage 7: roots and range test
   logic [NW-1:0]        n1_in, n2_in;
   logic                 s7_vld_ff, s7_ok1_ff, s7_ok2_ff, s7_dxneg_ff, s7_dyneg_ff;
   logic signed [W-1:0]  s7_sx_ff, s7_sy_ff;
   logic [W-1:0]         s7_mx_ff, s7_my_ff;
   logic [AB-1:0]        s7_n1_ff, s7_n2_ff, s7_a_ff;

   // stage 8: partial products of |d|*n, lanes x1, y1, x2, y2
   logic                        s8_vld_ff, s8_ok1_ff, s8_ok2_ff, s8_dxneg_ff, s8_dyneg_ff;
   logic signed [W-1:0]         s8_sx_ff, s8_sy_ff;
   logic [AB-1:0]               s8_a_ff;
   logic [3:0][W+HW-1:0]        s8_pl_ff, s8_ph_ff;

   // stage 9: numerators
   logic                        s9_vld_ff, s9_ok1_ff, s9_ok2_ff, s9_dxneg_ff, s9_dyneg_ff;
   logic signed [W-1:0]         s9_sx_ff, s9_sy_ff;
   logic [AB-1:0]               s9_a_ff;
   logic [3:0][NB-1:0]          s9_num_ff;

   // divider output
   logic                        dv_vld;
   logic [3:0][QB-1:0]          dv_quo;
   logic [SW2-1:0]              dv_side;
   logic signed [W-1:0]         dv_sx, dv_sy;
   logic                        dv_dxneg, dv_dyneg, dv_ok1, dv_ok2;

   // output stage
   logic signed [W+1:0]         ln_off [4];
   logic signed [W+1:0]         ln_sum [4];
   logic signed [W-1:0]         ln_pt  [4];
   logic                        out_vld_ff;
   logic [1:0]                  out_cnt_ff;
   logic signed [W-1:0]         out_p1x_ff, out_p1y_ff, out_p2x_ff, out_p2y_ff;

   // the whole pipeline moves whenever the output register can take a result
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   assign in_sx = req_tdata[W-1:0];
   assign in_sy = req_tdata[2*W-1:W];
   assign in_ex = req_tdata[3*W-1:2*W];
   assign in_ey = req_tdata[4*W-1:3*W];
   assign in_cx = req_tdata[5*W-1:4*W];
   assign in_cy = req_tdata[6*W-1:5*W];
   assign in_r  = req_tdata[7*W-2:6*W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         s9_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= req_tvalid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= s5_vld_ff;
         s7_vld_ff  <= sq_vld;
         s8_vld_ff  <= s7_vld_ff;
         s9_vld_ff  <= s8_vld_ff;
         out_vld_ff <= dv_vld;
      end
   end

   // stages 1 to 3
   always_ff @(posedge clock) begin
      if (en) begin
         s1_sx_ff  <= in_sx;
         s1_sy_ff  <= in_sy;
         s1_dx_ff  <= DW'(in_ex) - DW'(in_sx);
         s1_dy_ff  <= DW'(in_ey) - DW'(in_sy);
         s1_fx_ff  <= DW'(in_sx) - DW'(in_cx);
         s1_fy_ff  <= DW'(in_sy) - DW'(in_cy);
         s1_r_ff   <= in_r;

         s2_sx_ff  <= s1_sx_ff;
         s2_sy_ff  <= s1_sy_ff;
         s2_dx_ff  <= s1_dx_ff;
         s2_dy_ff  <= s1_dy_ff;
         s2_dxx_ff <= s1_dx_ff * s1_dx_ff;
         s2_dyy_ff <= s1_dy_ff * s1_dy_ff;
         s2_fdx_ff <= s1_fx_ff * s1_dx_ff;
         s2_fdy_ff <= s1_fy_ff * s1_dy_ff;
         s2_fxx_ff <= s1_fx_ff * s1_fx_ff;
         s2_fyy_ff <= s1_fy_ff * s1_fy_ff;
         s2_rr_ff  <= s1_r_ff * s1_r_ff;

         s3_sx_ff  <= s2_sx_ff;
         s3_sy_ff  <= s2_sy_ff;
         s3_dx_ff  <= s2_dx_ff;
         s3_dy_ff  <= s2_dy_ff;
         s3_a_ff   <= AB'($unsigned(s2_dxx_ff)) + AB'($unsigned(s2_dyy_ff));
         s3_h_ff   <= PW'(s2_fdx_ff) + PW'(s2_fdy_ff);
         s3_c_ff   <= PW'(s2_fxx_ff) + PW'(s2_fyy_ff) - $signed(PW'(s2_rr_ff));
      end
   end

   // stages 4 to 6: q = h*h - a*c, with the wide products split in halves
   assign ah_mag = s3_h_ff[PW-1] ? AB'(-s3_h_ff) : AB'(s3_h_ff);
   assign ac_mag = s3_c_ff[PW-1] ? AB'(-s3_c_ff) : AB'(s3_c_ff);
   assign ac_mid = (AB+1)'(s4_alh_ff) + (AB+1)'(s4_ahl_ff);
   assign q_in   = s5_cneg_ff ? ((QM+1)'(s5_hsq_ff) + (QM+1)'(s5_acp_ff))
                              : ((QM+1)'(s5_hsq_ff) - (QM+1)'(s5_acp_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         s4_sx_ff    <= s3_sx_ff;
         s4_sy_ff    <= s3_sy_ff;
         s4_dx_ff    <= s3_dx_ff;
         s4_dy_ff    <= s3_dy_ff;
         s4_a_ff     <= s3_a_ff;
         s4_h_ff     <= s3_h_ff;
         s4_cneg_ff  <= s3_c_ff[PW-1];
         s4_hll_ff   <= ah_mag[HW-1:0] * ah_mag[HW-1:0];
         s4_hlh_ff   <= ah_mag[HW-1:0] * ah_mag[AB-1:HW];
         s4_hhh_ff   <= ah_mag[AB-1:HW] * ah_mag[AB-1:HW];
         s4_all_ff   <= s3_a_ff[HW-1:0] * ac_mag[HW-1:0];
         s4_alh_ff   <= s3_a_ff[HW-1:0] * ac_mag[AB-1:HW];
         s4_ahl_ff   <= s3_a_ff[AB-1:HW] * ac_mag[HW-1:0];
         s4_ahh_ff   <= s3_a_ff[AB-1:HW] * ac_mag[AB-1:HW];

         s5_sx_ff    <= s4_sx_ff;
         s5_sy_ff    <= s4_sy_ff;
         s5_dx_ff    <= s4_dx_ff;
         s5_dy_ff    <= s4_dy_ff;
         s5_a_ff     <= s4_a_ff;
         s5_h_ff     <= s4_h_ff;
         s5_cneg_ff  <= s4_cneg_ff;
         s5_hsq_ff   <= {s4_hhh_ff, s4_hll_ff}
                      + {{(HW-1){1'b0}}, s4_hlh_ff, {(HW+1){1'b0}}};
         s5_acp_ff   <= {s4_ahh_ff, s4_all_ff}
                      + {{(HW-1){1'b0}}, ac_mid, {HW{1'b0}}};

         s6_sx_ff    <= s5_sx_ff;
         s6_sy_ff    <= s5_sy_ff;
         s6_dx_ff    <= s5_dx_ff;
         s6_dy_ff    <= s5_dy_ff;
         s6_a_ff     <= s5_a_ff;
         s6_h_ff     <= s5_h_ff;
         s6_q_ff     <= q_in[QM-1:0];
         s6_qneg_ff  <= q_in[QM];
         s6_azero_ff <= (s5_a_ff == '0);
      end
   end

   assign sq_step = '{advance: en, valid: s6_vld_ff};

   sci_sqrt #(
      .RW (AB),
      .SW (SW1)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .step_in  (sq_step),
      .rad_in   (s6_q_ff),
      .side_in  ({s6_h_ff, s6_a_ff, s6_sx_ff, s6_sy_ff, s6_dx_ff, s6_dy_ff,
                  s6_qneg_ff, s6_azero_ff}),
      .root_vld (sq_vld),
      .root_out (sq_root),
      .side_out (sq_side)
   );

   assign {sq_h, sq_a, sq_sx, sq_sy, sq_dx, sq_dy, sq_qneg, sq_azero} = sq_side;

   // stage 7: n = -h -/+ sqrt(q), keep roots with 0 <= n <= a
   assign n1_in = -NW'(sq_h) - NW'(sq_root);
   assign n2_in = -NW'(sq_h) + NW'(sq_root);

   always_ff @(posedge clock) begin
      if (en) begin
         s7_sx_ff    <= sq_sx;
         s7_sy_ff    <= sq_sy;
         s7_dxneg_ff <= sq_dx[DW-1];
         s7_dyneg_ff <= sq_dy[DW-1];
         s7_mx_ff    <= sq_dx[DW-1] ? W'(-sq_dx) : W'(sq_dx);
         s7_my_ff    <= sq_dy[DW-1] ? W'(-sq_dy) : W'(sq_dy);
         s7_n1_ff    <= n1_in[AB-1:0];
         s7_n2_ff    <= n2_in[AB-1:0];
         s7_a_ff     <= sq_a;
         s7_ok1_ff   <= !sq_qneg && !sq_azero && !n1_in[NW-1]
                        && (n1_in[NW-2:0] <= (NW-1)'(sq_a));
         s7_ok2_ff   <= !sq_qneg && !sq_azero && !n2_in[NW-1]
                        && (n2_in[NW-2:0] <= (NW-1)'(sq_a));
      end
   end

   // stages 8 and 9: |d| * n in two halves of n
   always_ff @(posedge clock) begin
      if (en) begin
         s8_sx_ff     <= s7_sx_ff;
         s8_sy_ff     <= s7_sy_ff;
         s8_dxneg_ff  <= s7_dxneg_ff;
         s8_dyneg_ff  <= s7_dyneg_ff;
         s8_ok1_ff    <= s7_ok1_ff;
         s8_ok2_ff    <= s7_ok2_ff;
         s8_a_ff      <= s7_a_ff;
         s8_pl_ff[0]  <= s7_mx_ff * s7_n1_ff[HW-1:0];
         s8_ph_ff[0]  <= s7_mx_ff * s7_n1_ff[AB-1:HW];
         s8_pl_ff[1]  <= s7_my_ff * s7_n1_ff[HW-1:0];
         s8_ph_ff[1]  <= s7_my_ff * s7_n1_ff[AB-1:HW];
         s8_pl_ff[2]  <= s7_mx_ff * s7_n2_ff[HW-1:0];
         s8_ph_ff[2]  <= s7_mx_ff * s7_n2_ff[AB-1:HW];
         s8_pl_ff[3]  <= s7_my_ff * s7_n2_ff[HW-1:0];
         s8_ph_ff[3]  <= s7_my_ff * s7_n2_ff[AB-1:HW];

         s9_sx_ff     <= s8_sx_ff;
         s9_sy_ff     <= s8_sy_ff;
         s9_dxneg_ff  <= s8_dxneg_ff;
         s9_dyneg_ff  <= s8_dyneg_ff;
         s9_ok1_ff    <= s8_ok1_ff;
         s9_ok2_ff    <= s8_ok2_ff;
         s9_a_ff      <= s8_a_ff;
         for (int i = 0; i < 4; i++) begin
            s9_num_ff[i] <= NB'(s8_pl_ff[i]) + {s8_ph_ff[i], {HW{1'b0}}};
         end
      end
   end

   assign dv_step = '{advance: en, valid: s9_vld_ff};

   sci_div #(
      .QB    (QB),
      .AB    (AB),
      .LANES (4),
      .SW    (SW2)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .step_in  (dv_step),
      .num_in   (s9_num_ff),
      .den_in   (s9_a_ff),
      .side_in  ({s9_sx_ff, s9_sy_ff, s9_dxneg_ff, s9_dyneg_ff, s9_ok1_ff, s9_ok2_ff}),
      .quo_vld  (dv_vld),
      .quo_out  (dv_quo),
      .side_out (dv_side)
   );

   assign {dv_sx, dv_sy, dv_dxneg, dv_dyneg, dv_ok1, dv_ok2} = dv_side;

   // point = start + signed offset, saturated to the coordinate range
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ln_off[i] = (i[0] ? dv_dyneg : dv_dxneg) ? -$signed({1'b0, dv_quo[i]})
                                                  : $signed({1'b0, dv_quo[i]});
         ln_sum[i] = (W+2)'(i[0] ? dv_sy : dv_sx) + ln_off[i];
         if (ln_sum[i] > PMAX) begin
            ln_pt[i] = PMAX[W-1:0];
         end else if (ln_sum[i] < PMIN) begin
            ln_pt[i] = PMIN[W-1:0];
         end else begin
            ln_pt[i] = ln_sum[i][W-1:0];
         end
      end
   end

   // compact: a lone second root moves into the first slot
   always_ff @(posedge clock) begin
      if (en) begin
         out_cnt_ff <= {dv_ok1 & dv_ok2, dv_ok1 ^ dv_ok2};
         if (dv_ok1) begin
            out_p1x_ff <= ln_pt[0];
            out_p1y_ff <= ln_pt[1];
         end else if (dv_ok2) begin
            out_p1x_ff <= ln_pt[2];
            out_p1y_ff <= ln_pt[3];
         end else begin
            out_p1x_ff <= '0;
            out_p1y_ff <= '0;
         end
         if (dv_ok1 && dv_ok2) begin
            out_p2x_ff <= ln_pt[2];
            out_p2y_ff <= ln_pt[3];
         end else begin
            out_p2x_ff <= '0;
            out_p2y_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = TOB'({out_p2y_ff, out_p2x_ff, out_p1y_ff, out_p1x_ff, out_cnt_ff});

`ifndef SYNTHESIS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while result is stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> out_cnt_ff != 2'd3)
      else $error("hit count out of range");

   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_cnt_ff == 2'd0 |-> out_p1x_ff == '0 && out_p1y_ff == '0)
      else $error("first point not cleared without hits");

   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_cnt_ff != 2'd2 |-> out_p2x_ff == '0 && out_p2y_ff == '0)
      else $error("second point not cleared");
`endif

endmodule

// ===== hdl/sci_sqrt.sv =====
// Pipelined floor square root, one root bit resolved per register stage.
module sci_sqrt #(
   parameter int RW = 66,
   parameter int SW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sci_pkg::sci_step_type step_in,
   input  logic [2*RW-1:0]       rad_in,
   input  logic [SW-1:0]         side_in,
   output logic                  root_vld,
   output logic [RW-1:0]         root_out,
   output logic [SW-1:0]         side_out
);
   import sci_pkg::*;

   logic            vld_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [SW-1:0]   side_ff [RW];
   logic [RW+1:0]   rem_ff  [RW-1];
   logic [2*RW-1:0] rad_ff  [RW-1];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW+1:0]   rem_p, sh, trial, rem_in;
      logic [RW-1:0]   root_p, root_in;
      logic [2*RW-1:0] rad_p;
      logic [SW-1:0]   side_p;
      logic            vld_p, ge;

      if (k == 0) begin : g_head
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = rad_in;
         assign side_p = side_in;
         assign vld_p  = step_in.valid;
      end else begin : g_body
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign side_p = side_ff[k-1];
         assign vld_p  = vld_ff[k-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign sh      = {rem_p[RW-1:0], rad_p[2*RW-1:2*RW-2]};
      assign trial   = {root_p, 2'b01};
      assign ge      = (sh >= trial);
      assign rem_in  = ge ? (sh - trial) : sh;
      assign root_in = {root_p[RW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (step_in.advance) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (step_in.advance) begin
            root_ff[k] <= root_in;
            side_ff[k] <= side_p;
         end
      end

      if (k < RW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (step_in.advance) begin
               rem_ff[k] <= rem_in;
               rad_ff[k] <= {rad_p[2*RW-3:0], 2'b00};
            end
         end
      end
   end

   assign root_vld = vld_ff[RW-1];
   assign root_out = root_ff[RW-1];
   assign side_out = side_ff[RW-1];

endmodule

// ===== hdl/sci_div.sv =====
// Pipelined restoring divider over several lanes sharing one divisor, rounded to nearest.
module sci_div #(
   parameter int QB    = 33,
   parameter int AB    = 66,
   parameter int LANES = 4,
   parameter int SW    = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sci_pkg::sci_step_type         step_in,
   input  logic [LANES-1:0][QB+AB-2:0]   num_in,
   input  logic [AB-1:0]                 den_in,
   input  logic [SW-1:0]                 side_in,
   output logic                          quo_vld,
   output logic [LANES-1:0][QB-1:0]      quo_out,
   output logic [SW-1:0]                 side_out
);
   import sci_pkg::*;

   logic                        vld_ff  [QB];
   logic [AB-1:0]               den_ff  [QB];
   logic [LANES-1:0][AB-1:0]    rem_ff  [QB];
   logic [LANES-1:0][QB-1:0]    quo_ff  [QB];
   logic [SW-1:0]               side_ff [QB];
   logic [LANES-1:0][QB-1:0]    lo_ff   [QB-1];

   logic                        rq_vld_ff;
   logic [LANES-1:0][QB-1:0]    rq_quo_ff, rq_quo_in;
   logic [SW-1:0]               rq_side_ff;

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [LANES-1:0][AB-1:0] rem_p, rem_in;
      logic [LANES-1:0][QB-1:0] quo_p, quo_in, lo_p;
      logic [LANES-1:0][AB:0]   t;
      logic [LANES-1:0]         ge;
      logic [AB-1:0]            den_p;
      logic [SW-1:0]            side_p;
      logic                     vld_p;

      if (k == 0) begin : g_head
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_p[l] = AB'(num_in[l][QB+AB-2:QB]);
               lo_p[l]  = num_in[l][QB-1:0];
            end
         end
         assign quo_p  = '0;
         assign den_p  = den_in;
         assign side_p = side_in;
         assign vld_p  = step_in.valid;
      end else begin : g_body
         assign rem_p  = rem_ff[k-1];
         assign lo_p   = lo_ff[k-1];
         assign quo_p  = quo_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign side_p = side_ff[k-1];
         assign vld_p  = vld_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            t[l]      = {rem_p[l], lo_p[l][QB-1]};
            ge[l]     = (t[l] >= {1'b0, den_p});
            rem_in[l] = ge[l] ? AB'(t[l] - {1'b0, den_p}) : AB'(t[l]);
            quo_in[l] = {quo_p[l][QB-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (step_in.advance) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (step_in.advance) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_p;
            side_ff[k] <= side_p;
         end
      end

      if (k < QB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (step_in.advance) begin
               for (int l = 0; l < LANES; l++) begin
                  lo_ff[k][l] <= {lo_p[l][QB-2:0], 1'b0};
               end
            end
         end
      end
   end

   // round half away from zero on the magnitude: bump when 2*rem >= den
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rq_quo_in[l] = quo_ff[QB-1][l]
                      + QB'({rem_ff[QB-1][l], 1'b0} >= {1'b0, den_ff[QB-1]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_vld_ff <= 1'b0;
      end else if (step_in.advance) begin
         rq_vld_ff <= vld_ff[QB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (step_in.advance) begin
         rq_quo_ff  <= rq_quo_in;
         rq_side_ff <= side_ff[QB-1];
      end
   end

   assign quo_vld  = rq_vld_ff;
   assign quo_out  = rq_quo_ff;
   assign side_out = rq_side_ff;

endmodule

// ===== test/tb_segment_circle_intersection_core.sv =====
// Self-checking testbench for the segment/circle intersection core.
`timescale 1ns / 100ps

module tb_segment_circle_intersection_core;

   localparam int CW = sci_pkg::COORD_WIDTH_DEF;
   localparam int REQ_W = ((7*CW+6)/8)*8;
   localparam int RSP_W = ((4*CW+9)/8)*8;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic [1:0]        hit_count;
      logic signed [31:0] first_x, first_y, second_x, second_y;
   } hits_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // start_x, start_y, end_x, end_y, centre_x, centre_y, circle_radius, zero pad
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // hit_count, first_x, first_y, second_x, second_y, zero pad
   logic [RSP_W-1:0] rsp_tdata;

   hits_type expected_hits[$];
   int    error_count = 0;
   bit    no_gaps = 1'b0;

   segment_circle_intersection_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic wide_type sat_point(wide_type s, wide_type d, wide_type n, wide_type a);
      wide_type num, mag, quo, rem, p;
      bit neg;
      num = d * n;
      neg = num < 0;
      mag = neg ? -num : num;
      quo = mag / a;
      rem = mag % a;
      if (rem * 2 >= a) quo = quo + 1;
      p = s + (neg ? -quo : quo);
      if (p > wide_type'(32'sh7fffffff)) p = wide_type'(32'sh7fffffff);
      if (p < wide_type'(-64'sh80000000)) p = wide_type'(-64'sh80000000);
      return p;
   endfunction

   function automatic logic [255:0] floor_sqrt(logic [255:0] v);
      logic [255:0] r, c;
      r = '0;
      for (int i = 127; i >= 0; i--) begin
         c = r | (256'd1 << i);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic hits_type predict_hits(logic [REQ_W-1:0] d);
      wide_type sx, sy, ex, ey, cx, cy, rad, dx, dy, fx, fy, a, h, c, q, s, n;
      hits_type res;
      int cnt;
      sx  = wide_type'($signed(d[31:0]));
      sy  = wide_type'($signed(d[63:32]));
      ex  = wide_type'($signed(d[95:64]));
      ey  = wide_type'($signed(d[127:96]));
      cx  = wide_type'($signed(d[159:128]));
      cy  = wide_type'($signed(d[191:160]));
      rad = wide_type'({1'b0, d[222:192]});
      dx = ex - sx; dy = ey - sy; fx = sx - cx; fy = sy - cy;
      a = dx*dx + dy*dy;
      h = fx*dx + fy*dy;
      c = fx*fx + fy*fy - rad*rad;
      q = h*h - a*c;
      res = '{2'd0, 0, 0, 0, 0};
      cnt = 0;
      if (a != 0 && q >= 0) begin
         s = floor_sqrt(q);
         for (int k = 0; k < 2; k++) begin
            n = (k == 0) ? -h - s : -h + s;
            if (n >= 0 && n <= a) begin
               if (cnt == 0) begin
                  res.first_x = 32'(sat_point(sx, dx, n, a));
                  res.first_y = 32'(sat_point(sy, dy, n, a));
               end else begin
                  res.second_x = 32'(sat_point(sx, dx, n, a));
                  res.second_y = 32'(sat_point(sy, dy, n, a));
               end
               cnt++;
            end
         end
      end
      res.hit_count = cnt[1:0];
      return res;
   endfunction

   // Record each accepted request and check each accepted result.
   always @(posedge clock) begin
      hits_type want;
      logic [1:0] got_count;
      logic signed [31:0] got_fx, got_fy, got_sx, got_sy;
      if (!reset && req_tvalid && req_tready)
         expected_hits = {expected_hits, predict_hits(req_tdata)};
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_count = rsp_tdata[1:0];
         got_fx = rsp_tdata[33:2];
         got_fy = rsp_tdata[65:34];
         got_sx = rsp_tdata[97:66];
         got_sy = rsp_tdata[129:98];
         if (expected_hits.size() == 0) begin
            $error("result with no request outstanding");
            error_count++;
         end else begin
            want = expected_hits.pop_front();
            if (got_count !== want.hit_count) begin
               $error("hit_count: expected %0d, got %0d", want.hit_count, got_count);
               error_count++;
            end
            if (got_fx !== want.first_x) begin
               $error("first_x: expected %0d, got %0d", want.first_x, got_fx);
               error_count++;
            end
            if (got_fy !== want.first_y) begin
               $error("first_y: expected %0d, got %0d", want.first_y, got_fy);
               error_count++;
            end
            if (got_sx !== want.second_x) begin
               $error("second_x: expected %0d, got %0d", want.second_x, got_sx);
               error_count++;
            end
            if (got_sy !== want.second_y) begin
               $error("second_y: expected %0d, got %0d", want.second_y, got_sy);
               error_count++;
            end
         end
      end
   end

   // Stall the result side at random.
   always @(negedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(99) >= 34);
   end

   // Only the low 31 bits of rad reach the request.
   task automatic send_request(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                               logic [31:0] ey, logic [31:0] cx, logic [31:0] cy,
                               logic [31:0] rad);
      while (!no_gaps && $urandom_range(99) < 34) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, rad[30:0], cy, cx, ey, ex, sy, sx};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] q16(int v);
      return v <<< 16;
   endfunction

   task automatic test_directed();
      // two crossings through the centre
      send_request(q16(-4), 0, q16(4), 0, 0, 0, q16(2));
      // miss: negative discriminant
      send_request(q16(-4), q16(5), q16(4), q16(5), 0, 0, q16(2));
      // tangent: two equal hits
      send_request(q16(-2), q16(1), q16(2), q16(1), 0, 0, q16(1));
      // zero-length segment
      send_request(q16(1), q16(1), q16(1), q16(1), 0, 0, q16(3));
      // start inside: only the larger root counts
      send_request(0, 0, q16(5), q16(3), 0, 0, q16(2));
      // end inside: only the smaller root counts
      send_request(q16(-5), q16(1), 0, 0, 0, 0, q16(2));
      // segment wholly inside the circle
      send_request(q16(-1), 0, q16(1), 0, 0, 0, q16(9));
      // segment short of the circle
      send_request(q16(-9), 0, q16(-5), 0, 0, 0, q16(2));
      // zero radius on the line
      send_request(q16(-1), 0, q16(1), 0, 0, 0, 0);
      send_request(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                   0, 0, 32'h7fffffff);
      send_request(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_request(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h40000000);
      send_request(32'hffffffff, 32'hffffffff, 32'h1, 32'h1, 0, 0, 32'h1);
      send_request(32'h7fffffff, 0, 32'h80000000, 0, 32'h7fffffff, 0, 0);
      send_request(0, 0, 0, 0, 0, 0, 0);
      send_request('1, '1, '1, '1, '1, '1, '1);
      // diagonal with rounding of both coordinates
      send_request(q16(-3) + 7, q16(-2) - 5, q16(3), q16(2) + 9, 13, -21, q16(2) + 3);
   endtask

   task automatic test_geometric(int count);
      int cx, cy, r, span;
      for (int i = 0; i < count; i++) begin
         no_gaps = (i >= count/3) && (i < count/3 + 120);
         span = (i % 5 == 0) ? (1 << 28) : (1 << 22);
         cx = $urandom_range(2*span) - span;
         cy = $urandom_range(2*span) - span;
         r  = $urandom_range(span);
         send_request(cx + $urandom_range(4*r + 2) - 2*r - 1,
                      cy + $urandom_range(4*r + 2) - 2*r - 1,
                      cx + $urandom_range(4*r + 2) - 2*r - 1,
                      cy + $urandom_range(4*r + 2) - 2*r - 1,
                      cx, cy, r);
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_full_range(int count);
      for (int i = 0; i < count; i++)
         send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_geometric(500);
      test_full_range(250);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/sci_pkg.sv
hdl/sci_sqrt.sv
hdl/sci_div.sv
hdl/segment_circle_intersection_core.sv
test/tb_segment_circle_intersection_core.sv
